FILE: sv/dpsa_pkg.sv
// Package: shared types, command and status codes, and the candidate mask table.
package dpsa_pkg;

  // Command codes
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RECLAIM = 2'd1;
  localparam logic [1:0] CMD_MERGE   = 2'd2;

  // Display codes
  localparam logic [1:0] DISP_PRIMARY  = 2'd0;
  localparam logic [1:0] DISP_EXTERNAL = 2'd1;

  // Plane kind codes
  localparam logic [1:0] KIND_PRIMARY = 2'd0;
  localparam logic [1:0] KIND_SPRITE  = 2'd1;
  localparam logic [1:0] KIND_OVERLAY = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  // Highest valid z-order slot
  localparam logic [2:0] SLOT_MAX = 3'd3;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_DISPLAY = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE    = 3'd2;
  localparam logic [2:0] ST_BAD_SLOT    = 3'd3;
  localparam logic [2:0] ST_NO_PLANE    = 3'd4;

  // Width of a candidate mask entry and of a plane index
  localparam int CAND_BITS = 32;
  localparam int IDX_BITS  = 5;

  // Candidate masks, indexed by {display[0], class, slot[1:0]}
  localparam logic [CAND_BITS-1:0] CAND_TABLE [16] = '{
    // primary display, RGB class
    32'h0000_0001, 32'h0000_0008, 32'h0000_0010, 32'h0000_0020,
    // primary display, overlay class
    32'h0000_0002, 32'h0000_0002, 32'h0000_0002, 32'h0000_0002,
    // external display, RGB class
    32'h0000_0002, 32'h0000_000a, 32'h0000_000a, 32'h0000_0008,
    // external display, overlay class
    32'h0000_0002, 32'h0000_0002, 32'h0000_0002, 32'h0000_0002
  };

  // Request and response payloads
  typedef struct packed {
    logic [1:0] command;
    logic [1:0] display;
    logic [1:0] plane_kind;
    logic [2:0] slot;
    logic [4:0] plane_number;
    logic [1:0] idle_flags;
  } req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [IDX_BITS-1:0] granted_index;
    logic                from_reclaimed;
  } rsp_t;

  // Bitmap update carried from the decode logic to the map registers
  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_TAKE,
    UPD_RETURN,
    UPD_MERGE
  } upd_op_t;

  typedef struct packed {
    upd_op_t    op;
    logic       cls;
    logic       from_reclaimed;
    logic [1:0] idle_flags;
  } upd_t;

endpackage

FILE: sv/dpsa_pick.sv
// Lowest candidate pick: isolates the first usable plane and encodes its index.
module dpsa_pick #(
  parameter int MAP_BITS = 32
) (
  input  logic [MAP_BITS-1:0]          cand,
  input  logic [MAP_BITS-1:0]          reclaimed,
  input  logic [MAP_BITS-1:0]          free,
  output logic                         found,
  output logic [MAP_BITS-1:0]          grant,
  output logic [dpsa_pkg::IDX_BITS-1:0] index,
  output logic                         from_reclaimed
);
  import dpsa_pkg::*;

  logic [MAP_BITS-1:0] hit;

  // Usable candidates, lowest one isolated by two's complement
  assign hit   = cand & (reclaimed | free);
  assign found = |hit;
  assign grant = hit & (~hit + MAP_BITS'(1));

  // Reclaimed bitmap wins over the free one for the chosen plane
  assign from_reclaimed = |(grant & reclaimed);

  // One-hot to binary
  always_comb begin
    index = '0;
    for (int i = 0; i < MAP_BITS; i++) begin
      if (grant[i]) begin
        index = index | IDX_BITS'(i);
      end
    end
  end

endmodule

FILE: sv/dpsa_maps.sv
// Free and reclaimed bitmaps for both plane classes, with their update logic.
module dpsa_maps #(
  parameter int MAP_BITS  = 32,
  parameter int RGB_LIMIT = 6,
  parameter int OVL_LIMIT = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dpsa_pkg::upd_t       upd,
  input  logic [MAP_BITS-1:0]  mask,
  output logic [MAP_BITS-1:0]  free_map [2],
  output logic [MAP_BITS-1:0]  reclaimed_map [2]
);
  import dpsa_pkg::*;

  localparam logic [MAP_BITS-1:0] ONES     = {MAP_BITS{1'b1}};
  localparam logic [MAP_BITS-1:0] RGB_MASK = ONES >> (MAP_BITS - RGB_LIMIT);
  localparam logic [MAP_BITS-1:0] OVL_MASK = ONES >> (MAP_BITS - OVL_LIMIT);

  // Bitmap registers
  always_ff @(posedge clk) begin
    if (rst) begin
      free_map[0]      <= RGB_MASK;
      free_map[1]      <= OVL_MASK;
      reclaimed_map[0] <= '0;
      reclaimed_map[1] <= '0;
    end else begin
      case (upd.op)
        UPD_TAKE: begin
          if (upd.from_reclaimed) begin
            reclaimed_map[upd.cls] <= reclaimed_map[upd.cls] & ~mask;
          end else begin
            free_map[upd.cls] <= free_map[upd.cls] & ~mask;
          end
        end
        UPD_RETURN: begin
          reclaimed_map[upd.cls] <= reclaimed_map[upd.cls] | mask;
        end
        UPD_MERGE: begin
          for (int c = 0; c < 2; c++) begin
            if (upd.idle_flags[c]) begin
              free_map[c]      <= free_map[c] | reclaimed_map[c];
              reclaimed_map[c] <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: sv/display_plane_slot_allocator.sv
// Top level: request register, command decode, bitmap update and response register.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | req (dpsa_pkg::req_t)
//  rsp     | out       | rsp_valid, rsp_stall | rsp (dpsa_pkg::rsp_t)
//
// One request per cycle is taken while req_stall is low; each gives one response,
// registered first in the request register and then in the response register.
// Decode and pick run between the two; the bitmaps update as the response is registered.
// Reset (synchronous) empties both registers and restores the bitmaps.
// A stalled response holds; the request register then holds too and
// req_stall rises while it is full.
module display_plane_slot_allocator #(
  parameter int PRIMARY_PLANES   = 3,
  parameter int RGB_CLASS_PLANES = 6,
  parameter int OVERLAY_PLANES   = 2,
  parameter int MAP_BITS         = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  dpsa_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output dpsa_pkg::rsp_t   rsp
);
  import dpsa_pkg::*;

  // Class sizes clipped to the bitmap width
  localparam int RGB_LIMIT = (RGB_CLASS_PLANES < MAP_BITS) ? RGB_CLASS_PLANES : MAP_BITS;
  localparam int OVL_LIMIT = (OVERLAY_PLANES < MAP_BITS) ? OVERLAY_PLANES : MAP_BITS;
  localparam logic [MAP_BITS-1:0] ONES     = {MAP_BITS{1'b1}};
  localparam logic [MAP_BITS-1:0] RGB_MASK = ONES >> (MAP_BITS - RGB_LIMIT);
  localparam logic [MAP_BITS-1:0] OVL_MASK = ONES >> (MAP_BITS - OVL_LIMIT);

  // Request register
  logic req_q_valid;
  req_t req_q;
  logic advance;

  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = req_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (!req_stall) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall) begin
      req_q <= req;
    end
  end

  // Candidate lookup
  logic                cls;
  logic [MAP_BITS-1:0] cand;
  logic [MAP_BITS-1:0] class_mask;

  assign cls        = (req_q.plane_kind == KIND_OVERLAY);
  assign class_mask = cls ? OVL_MASK : RGB_MASK;
  assign cand       = CAND_TABLE[{req_q.display[0], cls, req_q.slot[1:0]}][MAP_BITS-1:0]
                      & class_mask;

  // Bitmaps
  logic [MAP_BITS-1:0] free_map [2];
  logic [MAP_BITS-1:0] reclaimed_map [2];
  upd_t                upd;
  logic [MAP_BITS-1:0] upd_mask;

  dpsa_maps #(
    .MAP_BITS  (MAP_BITS),
    .RGB_LIMIT (RGB_LIMIT),
    .OVL_LIMIT (OVL_LIMIT)
  ) u_maps (
    .clk           (clk),
    .rst           (rst),
    .upd           (upd),
    .mask          (upd_mask),
    .free_map      (free_map),
    .reclaimed_map (reclaimed_map)
  );

  // Lowest usable candidate
  logic                found;
  logic [MAP_BITS-1:0] grant;
  logic [IDX_BITS-1:0] grant_index;
  logic                grant_reclaimed;

  dpsa_pick #(
    .MAP_BITS (MAP_BITS)
  ) u_pick (
    .cand           (cand),
    .reclaimed      (reclaimed_map[cls]),
    .free           (free_map[cls]),
    .found          (found),
    .grant          (grant),
    .index          (grant_index),
    .from_reclaimed (grant_reclaimed)
  );

  // Reclaim index: sprites sit after the primaries
  logic [IDX_BITS:0]   ret_index;
  logic                ret_ok;
  logic [MAP_BITS-1:0] ret_mask;

  assign ret_index = {1'b0, req_q.plane_number}
                     + ((req_q.plane_kind == KIND_SPRITE) ? (IDX_BITS+1)'(PRIMARY_PLANES)
                                                          : '0);
  assign ret_ok    = cls ? (ret_index < (IDX_BITS+1)'(OVL_LIMIT))
                         : (ret_index < (IDX_BITS+1)'(RGB_LIMIT));

  always_comb begin
    for (int i = 0; i < MAP_BITS; i++) begin
      ret_mask[i] = (ret_index == (IDX_BITS+1)'(i));
    end
  end

  // Command decode
  rsp_t    result;
  upd_op_t op;
  logic    fire;

  assign fire = req_q_valid && advance;

  always_comb begin
    result   = '0;
    op       = UPD_NONE;
    upd_mask = grant;
    case (req_q.command)
      CMD_ALLOC: begin
        if (req_q.display != DISP_PRIMARY && req_q.display != DISP_EXTERNAL) begin
          result.status = ST_BAD_DISPLAY;
        end else if (req_q.plane_kind == KIND_INVALID) begin
          result.status = ST_BAD_TYPE;
        end else if (req_q.slot > SLOT_MAX) begin
          result.status = ST_BAD_SLOT;
        end else if (!found) begin
          result.status = ST_NO_PLANE;
        end else begin
          result.status         = ST_OK;
          result.granted_index  = grant_index;
          result.from_reclaimed = grant_reclaimed;
          op                    = UPD_TAKE;
        end
      end
      CMD_RECLAIM: begin
        upd_mask = ret_mask;
        if (req_q.plane_kind == KIND_INVALID) begin
          result.status = ST_BAD_TYPE;
        end else if (!ret_ok) begin
          result.status = ST_NO_PLANE;
        end else begin
          op = UPD_RETURN;
        end
      end
      CMD_MERGE: begin
        op = UPD_MERGE;
      end
      default: begin
      end
    endcase
  end

  assign upd.op             = fire ? op : UPD_NONE;
  assign upd.cls            = cls;
  assign upd.from_reclaimed = grant_reclaimed;
  assign upd.idle_flags     = req_q.idle_flags;

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= result;
    end
  end

endmodule

FILE: sv/dpsa_checker.sv
// Port checker for the plane allocator, bound to the top level.
module dpsa_checker (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input dpsa_pkg::rsp_t rsp
);
  import dpsa_pkg::*;

  // A stalled response stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("response dropped while stalled");

  // Reset empties the response register
  a_rsp_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= ST_NO_PLANE)
    else $error("undefined status code");

  // Only a granted plane carries an index or a reclaimed mark
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.granted_index == '0 && !rsp.from_reclaimed)
    else $error("failed request carries grant fields");

endmodule

bind display_plane_slot_allocator dpsa_checker u_dpsa_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

FILE: test/tb_display_plane_slot_allocator.sv
// Testbench for display_plane_slot_allocator: directed table, random traffic, self-checking.
`timescale 1ns / 100ps

module tb_display_plane_slot_allocator;
  import dpsa_pkg::*;

  localparam int N_PRIMARY     = 3;
  localparam int N_RGB         = 6;
  localparam int N_OVERLAY     = 2;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int CYCLE_LIMIT   = 200000;

  // Codes the package leaves out
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] DISP_BAD   = 2'd3;

  // Z-order candidates, indexed by {display[0], class, slot[1:0]}
  localparam logic [31:0] ZORDER_CAND [0:15] = '{
    32'h01, 32'h08, 32'h10, 32'h20,
    32'h02, 32'h02, 32'h02, 32'h02,
    32'h02, 32'h0a, 32'h0a, 32'h08,
    32'h02, 32'h02, 32'h02, 32'h02
  };

  typedef struct packed {
    req_t r;
    logic typed;
    rsp_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Model state of the two plane classes
  logic [31:0] free_planes [0:1];
  logic [31:0] reclaimed_planes [0:1];

  rsp_t      pending_responses [$];
  stim_row_t stim_rows [$];
  int        errors = 0;
  int        cycle_count = 0;
  bit        quiet = 1'b0;
  int        n_transfers = 0;
  int        n_grants = 0;
  int        n_reused = 0;
  int        n_reclaims = 0;
  int        n_merges = 0;
  int        n_rejects = 0;

  display_plane_slot_allocator #(
    .PRIMARY_PLANES  (N_PRIMARY),
    .RGB_CLASS_PLANES(N_RGB),
    .OVERLAY_PLANES  (N_OVERLAY),
    .MAP_BITS        (32)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Planes that exist in a class
  function automatic logic [31:0] class_bits(input logic cls);
    return cls ? 32'((64'd1 << N_OVERLAY) - 1) : 32'((64'd1 << N_RGB) - 1);
  endfunction

  function automatic void reset_planes();
    free_planes[0] = class_bits(1'b0);
    free_planes[1] = class_bits(1'b1);
    reclaimed_planes[0] = '0;
    reclaimed_planes[1] = '0;
  endfunction

  // Expected response for one request; updates the plane maps
  function automatic rsp_t predict_plane_grant(input req_t r);
    rsp_t        res;
    logic        cls;
    logic        found;
    logic [31:0] cand;
    logic [31:0] exist;
    int          idx;
    res = '0;
    res.status = ST_OK;
    cls = (r.plane_kind == KIND_OVERLAY);
    found = 1'b0;
    case (r.command)
      CMD_ALLOC: begin
        if (r.display > DISP_EXTERNAL) begin
          res.status = ST_BAD_DISPLAY;
        end else if (r.plane_kind == KIND_INVALID) begin
          res.status = ST_BAD_TYPE;
        end else if (r.slot > SLOT_MAX) begin
          res.status = ST_BAD_SLOT;
        end else begin
          cand = ZORDER_CAND[{r.display[0], cls, r.slot[1:0]}] & class_bits(cls);
          // lowest candidate wins; a reclaimed plane beats a free one
          for (int i = 0; i < 32; i++) begin
            if (!found && cand[i]) begin
              if (reclaimed_planes[cls][i]) begin
                reclaimed_planes[cls][i] = 1'b0;
                res.granted_index = i[4:0];
                res.from_reclaimed = 1'b1;
                found = 1'b1;
              end else if (free_planes[cls][i]) begin
                free_planes[cls][i] = 1'b0;
                res.granted_index = i[4:0];
                found = 1'b1;
              end
            end
          end
          if (!found) res.status = ST_NO_PLANE;
        end
      end
      CMD_RECLAIM: begin
        if (r.plane_kind == KIND_INVALID) begin
          res.status = ST_BAD_TYPE;
        end else begin
          idx = int'(r.plane_number) + ((r.plane_kind == KIND_SPRITE) ? N_PRIMARY : 0);
          exist = class_bits(cls);
          if (idx >= 32 || !exist[idx % 32]) res.status = ST_NO_PLANE;
          else reclaimed_planes[cls][idx] = 1'b1;
        end
      end
      CMD_MERGE: begin
        for (int c = 0; c < 2; c++) begin
          if (r.idle_flags[c]) begin
            free_planes[c] = free_planes[c] | reclaimed_planes[c];
            reclaimed_planes[c] = '0;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void add_row(input logic [1:0] cmd, input logic [1:0] disp,
                                  input logic [1:0] kind, input logic [2:0] slot,
                                  input logic [4:0] pnum, input logic [1:0] idle,
                                  input logic typed, input logic [2:0] st,
                                  input logic [4:0] gidx, input logic rec);
    stim_row_t row;
    row.r = '{command: cmd, display: disp, plane_kind: kind, slot: slot,
              plane_number: pnum, idle_flags: idle};
    row.typed = typed;
    row.want = '{status: st, granted_index: gidx, from_reclaimed: rec};
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  // Present one request, wait for its transfer, record the expected response
  task automatic send_request(input req_t r, input logic typed, input rsp_t want);
    int   gap;
    rsp_t predicted;
    // idle gap grows by one while a draw from 0 to 99 falls below 38
    gap = 0;
    if (!quiet) begin
      while ($urandom_range(99) < 38) gap++;
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = predict_plane_grant(r);
    pending_responses.insert(pending_responses.size(), typed ? want : predicted);
    n_transfers++;
    if (predicted.status != ST_OK) n_rejects++;
    else if (r.command == CMD_ALLOC) begin
      n_grants++;
      if (predicted.from_reclaimed) n_reused++;
    end else if (r.command == CMD_RECLAIM) n_reclaims++;
    else if (r.command == CMD_MERGE) n_merges++;
  endtask

  // Hold off requests until every outstanding response is back
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_responses.size() != 0);
  endtask

  // Mostly well-formed commands with random content, some noise
  function automatic req_t random_request();
    req_t r;
    int   pick;
    r = req_t'($urandom);
    pick = $urandom_range(99);
    if (pick < 50) begin
      r.command = CMD_ALLOC;
      r.display = 2'($urandom_range(1));
      r.plane_kind = 2'($urandom_range(2));
      r.slot = 3'($urandom_range(3));
    end else if (pick < 75) begin
      r.command = CMD_RECLAIM;
      r.plane_kind = 2'($urandom_range(2));
      if ($urandom_range(9) != 0) begin
        r.plane_number = (r.plane_kind == KIND_OVERLAY) ? 5'($urandom_range(N_OVERLAY - 1))
                                                        : 5'($urandom_range(N_PRIMARY - 1));
      end
    end else if (pick < 85) begin
      r.command = CMD_MERGE;
    end
    return r;
  endfunction

  // Response check and receiver stall
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_responses.size() == 0) begin
          $error("unexpected response: status %0d index %0d reclaimed %0d",
                 rsp.status, rsp.granted_index, rsp.from_reclaimed);
          errors++;
        end else begin
          want = pending_responses.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.granted_index !== want.granted_index) begin
            $error("granted_index: expected %0d, got %0d", want.granted_index,
                   rsp.granted_index);
            errors++;
          end
          if (rsp.from_reclaimed !== want.from_reclaimed) begin
            $error("from_reclaimed: expected %0d, got %0d", want.from_reclaimed,
                   rsp.from_reclaimed);
            errors++;
          end
        end
      end
      rsp_stall <= !quiet && ($urandom_range(99) < 38);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Main sequence
  initial begin
    reset_planes();

    // Directed rows: error codes, extremes and reuse of reclaimed planes
    add_row(CMD_ALLOC, DISP_BAD, KIND_INVALID, 3'd7, 5'd31, 2'd3, 1, ST_BAD_DISPLAY, 0, 0);
    add_row(CMD_ALLOC, DISP_PRIMARY, KIND_INVALID, 3'd0, 5'd0, 2'd0, 1, ST_BAD_TYPE, 0, 0);
    add_row(CMD_ALLOC, DISP_EXTERNAL, KIND_SPRITE, 3'd4, 5'd0, 2'd0, 1, ST_BAD_SLOT, 0, 0);
    add_row(CMD_ALLOC, DISP_PRIMARY, KIND_OVERLAY, 3'd7, 5'd0, 2'd0, 1, ST_BAD_SLOT, 0, 0);
    add_row(CMD_ALLOC, DISP_PRIMARY, KIND_PRIMARY, 3'd0, 5'd0, 2'd0, 1, ST_OK, 0, 0);
    add_row(CMD_ALLOC, DISP_PRIMARY, KIND_PRIMARY, 3'd0, 5'd0, 2'd0, 1, ST_NO_PLANE, 0, 0);
    add_row(CMD_ALLOC, DISP_PRIMARY, KIND_OVERLAY, 3'd0, 5'd0, 2'd0, 1, ST_OK, 1, 0);
    add_row(CMD_ALLOC, DISP_EXTERNAL, KIND_OVERLAY, 3'd3, 5'd0, 2'd0, 1, ST_NO_PLANE, 0, 0);
    add_row(CMD_RECLAIM, DISP_BAD, KIND_INVALID, 3'd0, 5'd0, 2'd0, 1, ST_BAD_TYPE, 0, 0);
    add_row(CMD_RECLAIM, DISP_PRIMARY, KIND_PRIMARY, 3'd0, 5'd31, 2'd0, 1, ST_NO_PLANE, 0, 0);
    add_row(CMD_RECLAIM, DISP_PRIMARY, KIND_SPRITE, 3'd0, 5'd3, 2'd0, 1, ST_NO_PLANE, 0, 0);
    add_row(CMD_RECLAIM, DISP_PRIMARY, KIND_SPRITE, 3'd0, 5'd31, 2'd0, 1, ST_NO_PLANE, 0, 0);
    add_row(CMD_RECLAIM, DISP_PRIMARY, KIND_OVERLAY, 3'd0, 5'd2, 2'd0, 1, ST_NO_PLANE, 0, 0);
    add_row(CMD_RECLAIM, DISP_PRIMARY, KIND_PRIMARY, 3'd0, 5'd0, 2'd0, 0, ST_OK, 0, 0);
    add_row(CMD_ALLOC, DISP_PRIMARY, KIND_PRIMARY, 3'd0, 5'd0, 2'd0, 0, ST_OK, 0, 0);
    add_row(CMD_RECLAIM, DISP_EXTERNAL, KIND_OVERLAY, 3'd0, 5'd1, 2'd0, 0, ST_OK, 0, 0);
    add_row(CMD_MERGE, DISP_PRIMARY, KIND_PRIMARY, 3'd0, 5'd0, 2'd0, 0, ST_OK, 0, 0);
    add_row(CMD_ALLOC, DISP_EXTERNAL, KIND_OVERLAY, 3'd2, 5'd0, 2'd0, 0, ST_OK, 0, 0);
    add_row(CMD_RECLAIM, DISP_PRIMARY, KIND_SPRITE, 3'd0, 5'd0, 2'd0, 0, ST_OK, 0, 0);
    add_row(CMD_ALLOC, DISP_EXTERNAL, KIND_SPRITE, 3'd1, 5'd0, 2'd0, 0, ST_OK, 0, 0);
    add_row(CMD_ALLOC, DISP_EXTERNAL, KIND_SPRITE, 3'd2, 5'd0, 2'd0, 0, ST_OK, 0, 0);
    add_row(CMD_ALLOC, DISP_PRIMARY, KIND_SPRITE, 3'd3, 5'd0, 2'd0, 0, ST_OK, 0, 0);
    add_row(CMD_RECLAIM, DISP_PRIMARY, KIND_SPRITE, 3'd0, 5'd2, 2'd0, 0, ST_OK, 0, 0);
    add_row(CMD_MERGE, DISP_PRIMARY, KIND_PRIMARY, 3'd0, 5'd0, 2'd3, 0, ST_OK, 0, 0);
    add_row(CMD_UNUSED, DISP_BAD, KIND_INVALID, 3'd7, 5'd31, 2'd3, 1, ST_OK, 0, 0);
    add_row(CMD_ALLOC, DISP_PRIMARY, KIND_SPRITE, 3'd3, 5'd0, 2'd0, 0, ST_OK, 0, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) send_request(stim_rows[i].r, stim_rows[i].typed, stim_rows[i].want);

    // Random traffic with a quiet stretch and one full drain
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 300 && n < 500);
      if (n == 800) wait_drained();
      send_request(random_request(), 1'b0, '0);
    end
    quiet = 1'b0;

    wait_drained();
    repeat (6) @(posedge clk);

    $display("Ran %0d transfers: %0d grants (%0d reused reclaimed planes), %0d reclaims,",
             n_transfers, n_grants, n_reused, n_reclaims);
    $display("%0d merges, %0d rejected or unavailable requests.", n_merges, n_rejects);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
